/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh: concurrent assertion shorthands
// clocked checks with and without reset masking
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge while reset is released
`define SIPF_ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked on every rising edge, reset included
`define SIPF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/sipf_pkg.sv */
// ---------------------------------------------------------------------------
// sipf_pkg: shared definitions for the sip stream message framer
// byte codes, header names, parser phases and scan states
// ---------------------------------------------------------------------------
package sipf_pkg;

    localparam int SIPF_LENGTH_BITS = 16;
    localparam int SIPF_OUT_BITS    = 16;
    localparam int SIPF_OUT_MAX     = 65535;
    localparam int SIPF_TDATA_BITS  = 56;

    localparam logic [7:0] SIPF_BYTE_ESC   = 8'd27;
    localparam logic [7:0] SIPF_BYTE_CR    = 8'd13;
    localparam logic [7:0] SIPF_BYTE_LF    = 8'd10;
    localparam logic [7:0] SIPF_BYTE_HT    = 8'd9;
    localparam logic [7:0] SIPF_BYTE_VT    = 8'd11;
    localparam logic [7:0] SIPF_BYTE_FF    = 8'd12;
    localparam logic [7:0] SIPF_BYTE_SP    = 8'd32;
    localparam logic [7:0] SIPF_BYTE_PLUS  = 8'd43;
    localparam logic [7:0] SIPF_BYTE_MINUS = 8'd45;
    localparam logic [7:0] SIPF_BYTE_ZERO  = 8'd48;
    localparam logic [7:0] SIPF_BYTE_NINE  = 8'd57;
    localparam logic [7:0] SIPF_BYTE_UC_A  = 8'd65;
    localparam logic [7:0] SIPF_BYTE_UC_Z  = 8'd90;
    localparam logic [7:0] SIPF_CASE_DELTA = 8'd32;

    // header names, lower case, first character in the top byte
    localparam int SIPF_LONG_NAME_LEN  = 17;
    localparam int SIPF_SHORT_NAME_LEN = 4;
    localparam logic [8*SIPF_LONG_NAME_LEN-1:0] SIPF_LONG_NAME =
        {SIPF_BYTE_CR, SIPF_BYTE_LF, "content-length:"};
    localparam logic [8*SIPF_SHORT_NAME_LEN-1:0] SIPF_SHORT_NAME =
        {SIPF_BYTE_CR, SIPF_BYTE_LF, "l:"};

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_BLANKS,
        PH_NUMBER,
        PH_DONE
    } sipf_phase_t;

    typedef enum logic [1:0] {
        SCAN_NONE,
        SCAN_CR,
        SCAN_CRLF,
        SCAN_CRLFCR
    } sipf_scan_t;

    typedef struct packed {
        sipf_phase_t phase;
        logic        ovf;
    } sipf_field_t;

endpackage

/* hw/rtl/sip_stream_message_framer_core.sv */
// ---------------------------------------------------------------------------
// sip_stream_message_framer_core: frames back-to-back sip messages in a byte stream
// one byte per beat in, one length record per completed message out
// ---------------------------------------------------------------------------
// path: a closing byte passes the input byte register, then the record register
// throughput: one byte per cycle; all per-byte work sits between the input byte
//   register and the output record register, so the only wait is a full output
// reset: synchronous on aresetn low; control_mode returns to 0, all message state
//   and both stage valids clear, and a byte is accepted in the first cycle after
// ---------------------------------------------------------------------------
module sip_stream_message_framer_core
    import sipf_pkg::*;
#(
    parameter int LENGTH_BITS = SIPF_LENGTH_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration: control_mode
    input  logic                       cfg_wen,
    input  logic                       cfg_wdata,
    // byte stream in
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] data_byte
    // message records out
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [15:0] message_length, [31:16] header_length, [47:32] body_length,
    // [48] too_long, [55:49] zero
    output logic [SIPF_TDATA_BITS-1:0] m_tdata,
    output logic                       m_tuser    // [0] is_control
);

    localparam int WideBits = (LENGTH_BITS > SIPF_OUT_BITS) ? LENGTH_BITS : SIPF_OUT_BITS;
    localparam logic [LENGTH_BITS-1:0] LenMax = {LENGTH_BITS{1'b1}};

    function automatic logic over_out(input logic [LENGTH_BITS-1:0] v);
        logic [WideBits-1:0] w;
        w = WideBits'(v);
        return w > WideBits'(SIPF_OUT_MAX);
    endfunction

    function automatic logic [SIPF_OUT_BITS-1:0] clamp_out(input logic [LENGTH_BITS-1:0] v);
        logic [WideBits-1:0] w;
        w = WideBits'(v);
        return over_out(v) ? SIPF_OUT_BITS'(SIPF_OUT_MAX) : w[SIPF_OUT_BITS-1:0];
    endfunction

    // configuration
    logic mode_reg;

    // input byte stage
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       advance;

    // per-message state
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic                   sat_reg, sat_next;
    logic                   in_body_reg, in_body_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [LENGTH_BITS-1:0] hdr_held_reg, hdr_held_next;
    logic [LENGTH_BITS-1:0] body_held_reg, body_held_next;

    // record being formed this cycle
    logic                   emit;
    logic [LENGTH_BITS-1:0] rec_msg, rec_hdr, rec_body;
    logic                   rec_ctrl, rec_flag;
    logic                   parse_en;

    // submodule results
    sipf_field_t            long_field, short_field;
    logic [LENGTH_BITS-1:0] long_value, short_value;
    logic                   hdr_end;

    // output record stage
    logic                       m_valid_reg, m_valid_next;
    logic [SIPF_TDATA_BITS-1:0] m_data_reg;
    logic                       m_user_reg;

    // byte moves out of the input stage only when the record slot is free or being read
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign parse_en = advance && !mode_reg && !in_body_reg;

    sipf_field_parser #(
        .LENGTH_BITS (LENGTH_BITS),
        .NAME_LEN    (SIPF_LONG_NAME_LEN),
        .NAME        (SIPF_LONG_NAME)
    ) u_long_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (parse_en),
        .msg_clear  (emit),
        .data_byte  (in_byte_reg),
        .field_next (long_field),
        .value_next (long_value)
    );

    sipf_field_parser #(
        .LENGTH_BITS (LENGTH_BITS),
        .NAME_LEN    (SIPF_SHORT_NAME_LEN),
        .NAME        (SIPF_SHORT_NAME)
    ) u_short_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (parse_en),
        .msg_clear  (emit),
        .data_byte  (in_byte_reg),
        .field_next (short_field),
        .value_next (short_value)
    );

    sipf_hdr_scan u_hdr_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (parse_en),
        .msg_clear (emit),
        .data_byte (in_byte_reg),
        .end_seen  (hdr_end)
    );

    // per-byte message logic
    always_comb begin
        cnt_next       = cnt_reg;
        sat_next       = sat_reg;
        in_body_next   = in_body_reg;
        rem_next       = rem_reg;
        hdr_held_next  = hdr_held_reg;
        body_held_next = body_held_reg;
        emit           = 1'b0;
        rec_msg        = '0;
        rec_hdr        = '0;
        rec_body       = '0;
        rec_ctrl       = 1'b0;

        if (advance) begin
            // byte count sticks at its maximum and marks the message
            if (cnt_reg == LenMax) begin
                sat_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + LENGTH_BITS'(1);
            end

            priority if (mode_reg) begin
                // control mode: escape byte closes the message
                if (in_byte_reg == SIPF_BYTE_ESC) begin
                    emit     = 1'b1;
                    rec_msg  = cnt_next;
                    rec_hdr  = cnt_next;
                    rec_ctrl = 1'b1;
                end
            end else if (in_body_reg) begin
                // counting off body bytes
                rem_next = (rem_reg != '0) ? rem_reg - LENGTH_BITS'(1) : rem_reg;
                if (rem_next == '0) begin
                    emit     = 1'b1;
                    rec_msg  = cnt_next;
                    rec_hdr  = hdr_held_reg;
                    rec_body = body_held_reg;
                end
            end else if (hdr_end) begin
                // end of headers: long name wins once found, else compact name
                hdr_held_next  = cnt_next;
                body_held_next = '0;
                if (long_field.phase != PH_SEARCH) begin
                    if (long_field.phase == PH_DONE) begin
                        body_held_next = long_value;
                        if (long_field.ovf) begin
                            sat_next = 1'b1;
                        end
                    end
                end else if (short_field.phase != PH_SEARCH) begin
                    if (short_field.phase == PH_DONE) begin
                        body_held_next = short_value;
                        if (short_field.ovf) begin
                            sat_next = 1'b1;
                        end
                    end
                end
                if (body_held_next == '0) begin
                    emit    = 1'b1;
                    rec_msg = cnt_next;
                    rec_hdr = cnt_next;
                end else begin
                    in_body_next = 1'b1;
                    rem_next     = body_held_next;
                end
            end
        end

        // output clamp; any clamped field or a saturated message raises too_long
        rec_flag = sat_next || over_out(rec_msg) || over_out(rec_hdr) || over_out(rec_body);
    end

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control and message state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= 1'b0;
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            cnt_reg       <= '0;
            sat_reg       <= 1'b0;
            in_body_reg   <= 1'b0;
            rem_reg       <= '0;
            hdr_held_reg  <= '0;
            body_held_reg <= '0;
        end else begin
            if (cfg_wen) begin
                mode_reg <= cfg_wdata;
            end
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (emit) begin
                // a finished message starts the next one from scratch
                cnt_reg       <= '0;
                sat_reg       <= 1'b0;
                in_body_reg   <= 1'b0;
                rem_reg       <= '0;
                hdr_held_reg  <= '0;
                body_held_reg <= '0;
            end else begin
                cnt_reg       <= cnt_next;
                sat_reg       <= sat_next;
                in_body_reg   <= in_body_next;
                rem_reg       <= rem_next;
                hdr_held_reg  <= hdr_held_next;
                body_held_reg <= body_held_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (emit) begin
            m_data_reg <= {7'd0, rec_flag, clamp_out(rec_body), clamp_out(rec_hdr),
                           clamp_out(rec_msg)};
            m_user_reg <= rec_ctrl;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

/* hw/rtl/sipf_field_parser.sv */
// ---------------------------------------------------------------------------
// sipf_field_parser: header name match and decimal value parse
// case-insensitive name search, then blank skip, sign and digit accumulation
// ---------------------------------------------------------------------------
module sipf_field_parser
    import sipf_pkg::*;
#(
    parameter int LENGTH_BITS = SIPF_LENGTH_BITS,
    parameter int NAME_LEN    = SIPF_SHORT_NAME_LEN,
    parameter logic [8*NAME_LEN-1:0] NAME = SIPF_SHORT_NAME
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic                   msg_clear,
    input  logic [7:0]             data_byte,
    output sipf_field_t            field_next,
    output logic [LENGTH_BITS-1:0] value_next
);

    localparam int ProgBits = (NAME_LEN > 1) ? $clog2(NAME_LEN) : 1;
    localparam int WideBits = LENGTH_BITS + 4;
    localparam logic [LENGTH_BITS-1:0] ValMax = {LENGTH_BITS{1'b1}};

    logic [7:0]             name_chars [NAME_LEN];
    logic [ProgBits-1:0]    prog_reg, prog_next;
    sipf_phase_t            phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] value_reg, val_next;
    logic                   neg_reg, neg_next;
    logic                   ovf_reg, ovf_next;

    logic [7:0]          lc_byte;
    logic                is_digit, is_blank, is_eol;
    logic [WideBits-1:0] acc_wide, base_wide;

    for (genvar i = 0; i < NAME_LEN; i++) begin : g_name
        assign name_chars[i] = NAME[8*(NAME_LEN-1-i) +: 8];
    end

    always_comb begin
        lc_byte = (data_byte >= SIPF_BYTE_UC_A && data_byte <= SIPF_BYTE_UC_Z) ?
                  data_byte + SIPF_CASE_DELTA : data_byte;
        is_digit = (data_byte >= SIPF_BYTE_ZERO) && (data_byte <= SIPF_BYTE_NINE);
        is_blank = (data_byte == SIPF_BYTE_HT) || (data_byte == SIPF_BYTE_VT) ||
                   (data_byte == SIPF_BYTE_FF) || (data_byte == SIPF_BYTE_SP);
        is_eol   = (data_byte == SIPF_BYTE_CR) || (data_byte == SIPF_BYTE_LF);
        // value * 10 + digit, digits 0..9 sit in the low nibble
        base_wide = WideBits'(value_reg);
        acc_wide  = (base_wide << 3) + (base_wide << 1) + WideBits'(data_byte[3:0]);
    end

    always_comb begin
        prog_next  = prog_reg;
        phase_next = phase_reg;
        val_next   = value_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        if (step_en) begin
            unique case (phase_reg)
                PH_SEARCH: begin
                    if (lc_byte == name_chars[prog_reg]) begin
                        if (prog_reg == ProgBits'(NAME_LEN - 1)) begin
                            prog_next  = '0;
                            phase_next = PH_BLANKS;
                        end else begin
                            prog_next = prog_reg + ProgBits'(1);
                        end
                    end else begin
                        // a cr may open a new name
                        prog_next = (data_byte == SIPF_BYTE_CR) ? ProgBits'(1) : '0;
                    end
                end
                PH_BLANKS: begin
                    priority if (is_eol) begin
                        val_next   = '0;
                        phase_next = PH_DONE;
                    end else if (is_blank) begin
                        phase_next = PH_BLANKS;
                    end else if (data_byte == SIPF_BYTE_PLUS ||
                                 data_byte == SIPF_BYTE_MINUS) begin
                        neg_next   = (data_byte == SIPF_BYTE_MINUS);
                        val_next   = '0;
                        phase_next = PH_NUMBER;
                    end else if (is_digit) begin
                        val_next   = LENGTH_BITS'(data_byte[3:0]);
                        phase_next = PH_NUMBER;
                    end else begin
                        val_next   = '0;
                        phase_next = PH_DONE;
                    end
                end
                PH_NUMBER: begin
                    if (is_digit) begin
                        if (acc_wide[WideBits-1 -: 4] != 4'd0) begin
                            val_next = ValMax;
                            ovf_next = 1'b1;
                        end else begin
                            val_next = acc_wide[LENGTH_BITS-1:0];
                        end
                    end else begin
                        // bad terminator or negative value reads as zero
                        if (!(is_eol || is_blank) || neg_reg) begin
                            val_next = '0;
                            ovf_next = 1'b0;
                        end
                        phase_next = PH_DONE;
                    end
                end
                PH_DONE: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    phase_next = PH_SEARCH;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || msg_clear) begin
            prog_reg  <= '0;
            phase_reg <= PH_SEARCH;
            value_reg <= '0;
            neg_reg   <= 1'b0;
            ovf_reg   <= 1'b0;
        end else begin
            prog_reg  <= prog_next;
            phase_reg <= phase_next;
            value_reg <= val_next;
            neg_reg   <= neg_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign field_next.phase = phase_next;
    assign field_next.ovf   = ovf_next;
    assign value_next       = val_next;

endmodule

/* hw/rtl/sipf_hdr_scan.sv */
// ---------------------------------------------------------------------------
// sipf_hdr_scan: end of header detector
// tracks cr lf cr lf and flags the final lf
// ---------------------------------------------------------------------------
module sipf_hdr_scan
    import sipf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step_en,
    input  logic       msg_clear,
    input  logic [7:0] data_byte,
    output logic       end_seen
);

    sipf_scan_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        if (msg_clear) begin
            state_next = SCAN_NONE;
        end else if (step_en) begin
            unique case (state_reg)
                SCAN_NONE:   state_next = (data_byte == SIPF_BYTE_CR) ? SCAN_CR : SCAN_NONE;
                SCAN_CR:     state_next = (data_byte == SIPF_BYTE_LF) ? SCAN_CRLF : SCAN_NONE;
                SCAN_CRLF:   state_next = (data_byte == SIPF_BYTE_CR) ? SCAN_CRLFCR : SCAN_NONE;
                SCAN_CRLFCR: state_next = SCAN_NONE;
                default:     state_next = SCAN_NONE;
            endcase
        end
    end

    always_comb begin
        end_seen = step_en && (state_reg == SCAN_CRLFCR) && (data_byte == SIPF_BYTE_LF);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SCAN_NONE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/sipf_checker.sv */
// ---------------------------------------------------------------------------
// sipf_checker: port-level checks for the sip stream message framer
// record consistency and output stall behavior, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sipf_checker
    import sipf_pkg::*;
(
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       cfg_wen,
    input logic                       cfg_wdata,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [7:0]                 s_tdata,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [SIPF_TDATA_BITS-1:0] m_tdata,
    input logic                       m_tuser
);

    logic [SIPF_OUT_BITS:0] hdr_plus_body;

    assign hdr_plus_body = {1'b0, m_tdata[31:16]} + {1'b0, m_tdata[47:32]};

    // stalled beat keeps valid and payload
    `SIPF_ASSERT_CLK(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled record changed")

    // escape records carry no body and equal header and message lengths
    `SIPF_ASSERT_CLK(a_ctrl_record, aclk, aresetn, m_tvalid && m_tuser |-> m_tdata[47:32] == '0 && m_tdata[15:0] == m_tdata[31:16], "bad control record")

    // unsaturated sip record: message is header plus body
    `SIPF_ASSERT_CLK(a_len_sum, aclk, aresetn, m_tvalid && !m_tuser && !m_tdata[48] |-> hdr_plus_body == {1'b0, m_tdata[15:0]}, "message length mismatch")

    // no record right after reset
    `SIPF_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "record valid after reset")

endmodule

bind sip_stream_message_framer_core sipf_checker u_sipf_checker (.*);
